// ===== hdl/acm_pkg.sv =====
`timescale 1ns / 1ps

package acm_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
  localparam int EXT_WIDTH   = COORD_WIDTH + 1;
  localparam int SUM_WIDTH   = COORD_WIDTH + 2;
  localparam int OV_WIDTH    = COORD_WIDTH + 3;
  localparam int NUM_STAGES  = 8;
  localparam int CFG_IDX_W   = 2;

  typedef logic [NUM_STAGES-1:0] pipe_en_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOCAL_MIN_X = 2'd0,
    CFG_LOCAL_MIN_Y = 2'd1,
    CFG_LOCAL_MAX_X = 2'd2,
    CFG_LOCAL_MAX_Y = 2'd3
  } cfg_idx_t;

  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic signed [COORD_WIDTH-1:0] HALF_POS  = COORD_WIDTH'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [COORD_WIDTH-1:0] HALF_NEG  = -HALF_POS;
  localparam logic [PROD_WIDTH-1:0] PROD_LIMIT = (PROD_WIDTH'(1) << (COORD_WIDTH - 1)) - 1'b1;

  localparam logic signed [1:0] NORM_ZERO = 2'sb00;
  localparam logic signed [1:0] NORM_POS  = 2'sb01;
  localparam logic signed [1:0] NORM_NEG  = 2'sb11;

  function automatic logic signed [COORD_WIDTH-1:0] fx_trunc_sat(
    input logic signed [PROD_WIDTH-1:0] p
  );
    logic                   neg;
    logic [PROD_WIDTH-1:0]  mg;
    logic [PROD_WIDTH-1:0]  q;
    logic [PROD_WIDTH-1:0]  lim;
    logic [COORD_WIDTH-1:0] qs;
    neg = p[PROD_WIDTH-1];
    mg  = neg ? unsigned'(-p) : unsigned'(p);
    q   = mg >> FRAC_BITS;
    lim = PROD_LIMIT + PROD_WIDTH'(neg);
    if (q > lim) begin
      q = lim;
    end
    qs = q[COORD_WIDTH-1:0];
    qs = neg ? (~qs + COORD_WIDTH'(1)) : qs;
    return signed'(qs);
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] sat_add(
    input logic signed [COORD_WIDTH-1:0] a,
    input logic signed [COORD_WIDTH-1:0] b
  );
    logic signed [EXT_WIDTH-1:0] s;
    s = EXT_WIDTH'(a) + EXT_WIDTH'(b);
    if (s[COORD_WIDTH] != s[COORD_WIDTH-1]) begin
      return s[COORD_WIDTH] ? COORD_MIN : COORD_MAX;
    end
    return signed'(s[COORD_WIDTH-1:0]);
  endfunction

endpackage

// ===== hdl/acm_pipe_ctrl.sv =====
`timescale 1ns / 1ps

module acm_pipe_ctrl
  import acm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output pipe_en_t en
);

  logic [NUM_STAGES-1:0] v_r, v_nxt, rdy;

  always_comb begin
    rdy[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt[0] = rdy[0] ? in_valid : v_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign en        = rdy;
  assign in_ready  = rdy[0];
  assign out_valid = v_r[NUM_STAGES-1];

endmodule

// ===== hdl/acm_fx_mul.sv =====
`timescale 1ns / 1ps

module acm_fx_mul
  import acm_pkg::*;
(
  input  logic                          clk,
  input  logic [1:0]                    en,
  input  logic signed [COORD_WIDTH-1:0] a,
  input  logic signed [COORD_WIDTH-1:0] b,
  output logic signed [COORD_WIDTH-1:0] m
);

  logic signed [PROD_WIDTH-1:0]  prod_r;
  logic signed [COORD_WIDTH-1:0] m_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_r <= PROD_WIDTH'(a) * PROD_WIDTH'(b);
    end
    if (en[1]) begin
      m_r <= fx_trunc_sat(prod_r);
    end
  end

  assign m = m_r;

endmodule

// ===== hdl/acm_bound.sv =====
`timescale 1ns / 1ps

module acm_bound
  import acm_pkg::*;
(
  input  logic                          clk,
  input  pipe_en_t                      en,
  input  logic signed [COORD_WIDTH-1:0] pos,
  input  logic signed [COORD_WIDTH-1:0] lcl,
  input  logic signed [COORD_WIDTH-1:0] scale,
  input  logic signed [COORD_WIDTH-1:0] size,
  output logic signed [COORD_WIDTH-1:0] bnd
);

  logic signed [COORD_WIDTH-1:0] size_d0_r, size_d1_r;
  logic signed [COORD_WIDTH-1:0] pos_d0_r, pos_d1_r, pos_d2_r, pos_d3_r;
  logic signed [COORD_WIDTH-1:0] ls, lss;
  logic signed [COORD_WIDTH-1:0] bnd_r;

  acm_fx_mul u_mul_scale (
    .clk (clk),
    .en  (en[1:0]),
    .a   (lcl),
    .b   (scale),
    .m   (ls)
  );

  acm_fx_mul u_mul_size (
    .clk (clk),
    .en  (en[3:2]),
    .a   (ls),
    .b   (size_d1_r),
    .m   (lss)
  );

  always_ff @(posedge clk) begin
    if (en[0]) begin
      size_d0_r <= size;
      pos_d0_r  <= pos;
    end
    if (en[1]) begin
      size_d1_r <= size_d0_r;
      pos_d1_r  <= pos_d0_r;
    end
    if (en[2]) begin
      pos_d2_r <= pos_d1_r;
    end
    if (en[3]) begin
      pos_d3_r <= pos_d2_r;
    end
    if (en[4]) begin
      bnd_r <= sat_add(pos_d3_r, lss);
    end
  end

  assign bnd = bnd_r;

endmodule

// ===== hdl/acm_manifold.sv =====
`timescale 1ns / 1ps

module acm_manifold
  import acm_pkg::*;
(
  input  logic                          clk,
  input  pipe_en_t                      en,
  input  logic signed [COORD_WIDTH-1:0] a_min_x,
  input  logic signed [COORD_WIDTH-1:0] a_max_x,
  input  logic signed [COORD_WIDTH-1:0] a_min_y,
  input  logic signed [COORD_WIDTH-1:0] a_max_y,
  input  logic signed [COORD_WIDTH-1:0] b_min_x,
  input  logic signed [COORD_WIDTH-1:0] b_max_x,
  input  logic signed [COORD_WIDTH-1:0] b_min_y,
  input  logic signed [COORD_WIDTH-1:0] b_max_y,
  output logic                          hit,
  output logic signed [1:0]             normal_x,
  output logic signed [1:0]             normal_y,
  output logic signed [COORD_WIDTH-1:0] depth
);

  // stage 5: overlap test, extents, doubled center difference
  logic                          hit5_r;
  logic signed [EXT_WIDTH-1:0]   eax_r, ebx_r, eay_r, eby_r;
  logic signed [SUM_WIDTH-1:0]   nx_r, ny_r;

  // stage 6: doubled overlap per axis
  logic                          hit6_r, nx_neg_r, ny_neg_r;
  logic signed [OV_WIDTH-1:0]    ox_r, oy_r;
  logic signed [SUM_WIDTH-1:0]   anx, any;

  // stage 7: result
  logic                          hit_r;
  logic signed [1:0]             normal_x_r, normal_y_r;
  logic signed [COORD_WIDTH-1:0] depth_r;
  logic                          pick_x;
  logic signed [OV_WIDTH-1:0]    dsel, dhalf;
  logic signed [COORD_WIDTH-1:0] dsat;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      hit5_r <= (a_min_x <= b_max_x) && (a_max_x >= b_min_x) &&
                (a_min_y <= b_max_y) && (a_max_y >= b_min_y);
      eax_r  <= EXT_WIDTH'(a_max_x) - EXT_WIDTH'(a_min_x);
      ebx_r  <= EXT_WIDTH'(b_max_x) - EXT_WIDTH'(b_min_x);
      eay_r  <= EXT_WIDTH'(a_max_y) - EXT_WIDTH'(a_min_y);
      eby_r  <= EXT_WIDTH'(b_max_y) - EXT_WIDTH'(b_min_y);
      nx_r   <= (SUM_WIDTH'(b_min_x) + SUM_WIDTH'(b_max_x)) -
                (SUM_WIDTH'(a_min_x) + SUM_WIDTH'(a_max_x));
      ny_r   <= (SUM_WIDTH'(b_min_y) + SUM_WIDTH'(b_max_y)) -
                (SUM_WIDTH'(a_min_y) + SUM_WIDTH'(a_max_y));
    end
  end

  assign anx = nx_r[SUM_WIDTH-1] ? -nx_r : nx_r;
  assign any = ny_r[SUM_WIDTH-1] ? -ny_r : ny_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      hit6_r   <= hit5_r;
      nx_neg_r <= nx_r[SUM_WIDTH-1];
      ny_neg_r <= ny_r[SUM_WIDTH-1];
      ox_r     <= OV_WIDTH'(eax_r) + OV_WIDTH'(ebx_r) - OV_WIDTH'(anx);
      oy_r     <= OV_WIDTH'(eay_r) + OV_WIDTH'(eby_r) - OV_WIDTH'(any);
    end
  end

  always_comb begin
    pick_x = ox_r < oy_r;
    dsel   = pick_x ? ox_r : oy_r;
    dhalf  = dsel >>> 1;
    if (dhalf[OV_WIDTH-1:COORD_WIDTH-1] == '0 ||
        dhalf[OV_WIDTH-1:COORD_WIDTH-1] == '1) begin
      dsat = signed'(dhalf[COORD_WIDTH-1:0]);
    end else begin
      dsat = dhalf[OV_WIDTH-1] ? COORD_MIN : COORD_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      hit_r <= hit6_r;
      if (!hit6_r) begin
        normal_x_r <= NORM_ZERO;
        normal_y_r <= NORM_ZERO;
        depth_r    <= '0;
      end else if (pick_x) begin
        normal_x_r <= nx_neg_r ? NORM_NEG : NORM_POS;
        normal_y_r <= NORM_ZERO;
        depth_r    <= dsat;
      end else begin
        normal_x_r <= NORM_ZERO;
        normal_y_r <= ny_neg_r ? NORM_NEG : NORM_POS;
        depth_r    <= dsat;
      end
    end
  end

  assign hit      = hit_r;
  assign normal_x = normal_x_r;
  assign normal_y = normal_y_r;
  assign depth    = depth_r;

endmodule

// ===== hdl/aabb_collision_manifold_core.sv =====
`timescale 1ns / 1ps
// Throughput: one request per cycle while out_ready does not stall the pipeline; eight
// register stages (two multiply/saturate pairs, bound add, overlap test, overlap sum,
// result select) advance independently on ready. Reset (rst_n, synchronous, active
// low) empties the pipeline and sets the local bounds to -0.5 / +0.5.

module aabb_collision_manifold_core
  import acm_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_a_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_a_scale_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_scale_y,
  input  logic signed [COORD_WIDTH-1:0] in_a_size_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_size_y,
  input  logic signed [COORD_WIDTH-1:0] in_b_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_b_scale_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_scale_y,
  input  logic signed [COORD_WIDTH-1:0] in_b_size_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_size_y,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic signed [1:0]             out_normal_x,
  output logic signed [1:0]             out_normal_y,
  output logic signed [COORD_WIDTH-1:0] out_depth,

  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic signed [COORD_WIDTH-1:0] cfg_data
);

  pipe_en_t en;

  logic signed [COORD_WIDTH-1:0] local_min_x_r, local_min_y_r;
  logic signed [COORD_WIDTH-1:0] local_max_x_r, local_max_y_r;

  logic signed [COORD_WIDTH-1:0] a_min_x, a_max_x, a_min_y, a_max_y;
  logic signed [COORD_WIDTH-1:0] b_min_x, b_max_x, b_min_y, b_max_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_min_x_r <= HALF_NEG;
      local_min_y_r <= HALF_NEG;
      local_max_x_r <= HALF_POS;
      local_max_y_r <= HALF_POS;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LOCAL_MIN_X: local_min_x_r <= cfg_data;
        CFG_LOCAL_MIN_Y: local_min_y_r <= cfg_data;
        CFG_LOCAL_MAX_X: local_max_x_r <= cfg_data;
        CFG_LOCAL_MAX_Y: local_max_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  acm_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .en        (en)
  );

  acm_bound u_a_min_x (
    .clk (clk), .en (en), .pos (in_a_pos_x), .lcl (local_min_x_r),
    .scale (in_a_scale_x), .size (in_a_size_x), .bnd (a_min_x)
  );

  acm_bound u_a_max_x (
    .clk (clk), .en (en), .pos (in_a_pos_x), .lcl (local_max_x_r),
    .scale (in_a_scale_x), .size (in_a_size_x), .bnd (a_max_x)
  );

  acm_bound u_a_min_y (
    .clk (clk), .en (en), .pos (in_a_pos_y), .lcl (local_min_y_r),
    .scale (in_a_scale_y), .size (in_a_size_y), .bnd (a_min_y)
  );

  acm_bound u_a_max_y (
    .clk (clk), .en (en), .pos (in_a_pos_y), .lcl (local_max_y_r),
    .scale (in_a_scale_y), .size (in_a_size_y), .bnd (a_max_y)
  );

  acm_bound u_b_min_x (
    .clk (clk), .en (en), .pos (in_b_pos_x), .lcl (local_min_x_r),
    .scale (in_b_scale_x), .size (in_b_size_x), .bnd (b_min_x)
  );

  acm_bound u_b_max_x (
    .clk (clk), .en (en), .pos (in_b_pos_x), .lcl (local_max_x_r),
    .scale (in_b_scale_x), .size (in_b_size_x), .bnd (b_max_x)
  );

  acm_bound u_b_min_y (
    .clk (clk), .en (en), .pos (in_b_pos_y), .lcl (local_min_y_r),
    .scale (in_b_scale_y), .size (in_b_size_y), .bnd (b_min_y)
  );

  acm_bound u_b_max_y (
    .clk (clk), .en (en), .pos (in_b_pos_y), .lcl (local_max_y_r),
    .scale (in_b_scale_y), .size (in_b_size_y), .bnd (b_max_y)
  );

  acm_manifold u_manifold (
    .clk      (clk),
    .en       (en),
    .a_min_x  (a_min_x),
    .a_max_x  (a_max_x),
    .a_min_y  (a_min_y),
    .a_max_y  (a_max_y),
    .b_min_x  (b_min_x),
    .b_max_x  (b_max_x),
    .b_min_y  (b_min_y),
    .b_max_y  (b_max_y),
    .hit      (out_hit),
    .normal_x (out_normal_x),
    .normal_y (out_normal_y),
    .depth    (out_depth)
  );

endmodule
